### rtl/core/rhpt_pkg.sv
// rhpt_pkg: shared types and codes for the robin hood pointer table
// no dependencies

package rhpt_pkg;

    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 32;
    localparam int COUNT_W = 11;
    localparam logic [KEY_W-1:0] HASH_MUL = 64'd13;
    localparam int HASH_SHIFT = 15;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FRD,
        S_FCHK,
        S_PRD,
        S_PCHK,
        S_URD,
        S_UCHK,
        S_OUT
    } state_t;

    // item layouts carried by the two channels
    typedef struct packed {
        kind_t               kind;
        logic [KEY_W-1:0]    key;
        logic [SIZE_W-1:0]   entry_size;
    } op_item_t;

    typedef struct packed {
        status_t             status;
        logic [SIZE_W-1:0]   found_size;
        logic [COUNT_W-1:0]  entry_count;
    } result_item_t;

endpackage

### rtl/core/rhpt_if.sv
// rhpt_if: valid/ready channel carrying a parameterized payload
// depends on nothing

interface rhpt_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/rhpt_ram.sv
// rhpt_ram: generic single-port ram, registered read
// no dependencies

module rhpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/core/robin_hood_pointer_table.sv
// robin_hood_pointer_table: robin hood hash table with backward-shift delete
// depends on rhpt_pkg, rhpt_if, rhpt_ram
//
// One item (insert, lookup or remove) is processed at a time over a single-port
// entry memory, at most one slot access per cycle. After reset a clearing pass
// writes every slot empty, during which no item is accepted. An item is then
// taken, its hash is folded (a power-of-two table needs at most one fold) and
// finished, the lookup walk reads and checks each slot probed, the insert walk
// reads and checks each slot visited, the remove shift reads and moves each
// entry, then reads the slot that ends it and clears the last copy, and the
// result is presented. The result sits in an output register until taken,
// and the next item is accepted once it is taken. The key search before insert
// and remove uses the same walk as lookup.

module robin_hood_pointer_table
    import rhpt_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic clk,
    input  logic rst_n,
    rhpt_if.sink   in_ch,
    rhpt_if.source out_ch
);
    localparam int AW = $clog2(SLOTS);
    localparam int HW = $clog2(SLOTS + 1);   // home plus one
    localparam int CW = $clog2(SLOTS + 1);   // count
    localparam int EW = KEY_W + SIZE_W + HW;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
    // 2^AW reduced mod SLOTS, zero for a power-of-two table
    localparam logic [AW-1:0] FOLD_R = AW'((1 << AW) - SLOTS);

    state_t state_reg, state_next;

    // operation registers
    kind_t             kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SIZE_W-1:0] sz_reg, sz_next;
    logic [KEY_W-1:0]  hash_reg, hash_next;
    logic [AW-1:0]     p_reg, p_next;
    logic [CW-1:0]     d_reg, d_next;      // carried probe distance
    logic [CW-1:0]     n_reg, n_next;      // walk step count
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [HW-1:0]     ch_reg, ch_next;    // carried home plus one
    logic [1:0]        st_reg, st_next;
    logic [SIZE_W-1:0] fs_reg, fs_next;

    // memory port
    logic          we;
    logic [AW-1:0] addr;
    logic [EW-1:0] wdata, rdata;

    rhpt_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    logic [KEY_W-1:0]  r_key;
    logic [SIZE_W-1:0] r_size;
    logic [HW-1:0]     r_home;
    assign {r_key, r_size, r_home} = rdata;

    // distance of slot p_reg from stored home plus one
    logic [AW-1:0] r_homeslot;
    logic [CW-1:0] r_dist;
    assign r_homeslot = AW'(r_home - HW'(1));
    always_comb
    begin
        if (p_reg >= r_homeslot)
        begin
            r_dist = CW'(p_reg - r_homeslot);
        end
        else
        begin
            r_dist = CW'(SLOTS) - CW'(r_homeslot) + CW'(p_reg);
        end
    end

    logic [AW-1:0] p_inc;
    assign p_inc = (p_reg == LAST) ? '0 : p_reg + AW'(1);

    // hash reduction: fold the bits above AW back in until none are left,
    // then one conditional subtract brings the value below SLOTS
    logic [AW-1:0]    hash_mod;
    logic [AW-1:0]    hash_home;
    logic [KEY_W-1:0] hash_fold;
    assign hash_mod  = hash_reg[AW-1:0];
    assign hash_fold = (hash_reg >> AW) * KEY_W'(FOLD_R) + KEY_W'(hash_mod);
    assign hash_home = ({1'b0, hash_mod} >= (AW+1)'(SLOTS))
                     ? hash_mod - AW'(SLOTS) : hash_mod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            p_reg     <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        key_reg  <= key_next;
        sz_reg   <= sz_next;
        hash_reg <= hash_next;
        d_reg    <= d_next;
        n_reg    <= n_next;
        ch_reg   <= ch_next;
        st_reg   <= st_next;
        fs_reg   <= fs_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        sz_next    = sz_reg;
        hash_next  = hash_reg;
        p_next     = p_reg;
        d_next     = d_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        st_next    = st_reg;
        fs_next    = fs_reg;
        we         = 1'b0;
        addr       = p_reg;
        wdata      = '0;
        in_ch.ready = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                p_next = p_inc;
                if (p_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    kind_next = kind_t'(in_ch.data.kind);
                    key_next  = in_ch.data.key;
                    sz_next   = in_ch.data.entry_size;
                    // multiply stage of the hash
                    hash_next = (in_ch.data.key * HASH_MUL)
                              ^ (in_ch.data.key >> HASH_SHIFT);
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_reg[KEY_W-1:AW] != '0)
                begin
                    // 2^AW is congruent to FOLD_R, so the fold keeps the residue
                    hash_next = hash_fold;
                end
                else
                begin
                    hash_next = KEY_W'(hash_home);
                    p_next = hash_home;
                    d_next = '0;
                    n_next = '0;
                    st_next = ST_NOTFOUND;
                    fs_next = '0;
                    if (kind_reg == KIND_UNUSED
                        || (kind_reg == KIND_REMOVE && cnt_reg == '0))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                // read issued at p_reg
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (r_home == '0 || d_reg > r_dist || n_reg == CW'(SLOTS))
                begin
                    // key absent
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (cnt_reg >= CW'(SLOTS))
                        begin
                            st_next = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            p_next  = AW'(hash_mod);
                            d_next  = '0;
                            n_next  = '0;
                            ch_next = HW'(hash_mod) + HW'(1);
                            state_next = S_PRD;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else if (r_key == key_reg)
                begin
                    unique case (kind_reg)
                        KIND_INSERT: st_next = ST_PRESENT;
                        KIND_LOOKUP:
                        begin
                            st_next = ST_DONE;
                            fs_next = r_size;
                        end
                        default: st_next = ST_DONE;
                    endcase
                    if (kind_reg == KIND_REMOVE)
                    begin
                        // clear found slot, then shift followers back
                        we = 1'b1;
                        wdata = '0;
                        n_next = '0;
                        cnt_next = cnt_reg - CW'(1);
                        state_next = S_URD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    p_next = p_inc;
                    d_next = d_reg + CW'(1);
                    n_next = n_reg + CW'(1);
                    state_next = S_FRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (r_home == '0)
                begin
                    we = 1'b1;
                    wdata = {key_reg, sz_reg, ch_reg};
                    cnt_next = cnt_reg + CW'(1);
                    st_next = ST_DONE;
                    state_next = S_OUT;
                end
                else
                begin
                    if (d_reg > r_dist)
                    begin
                        // swap carried entry with resident
                        we = 1'b1;
                        wdata = {key_reg, sz_reg, ch_reg};
                        key_next = r_key;
                        sz_next  = r_size;
                        ch_next  = r_home;
                        d_next   = r_dist + CW'(1);
                    end
                    else
                    begin
                        d_next = d_reg + CW'(1);
                    end
                    p_next = p_inc;
                    n_next = n_reg + CW'(1);
                    state_next = (n_reg == CW'(SLOTS - 1)) ? S_OUT : S_PRD;
                    if (n_reg == CW'(SLOTS - 1))
                    begin
                        cnt_next = cnt_reg + CW'(1);
                        st_next = ST_DONE;
                    end
                end
            end
            S_URD:
            begin
                // read next slot
                addr = p_inc;
                state_next = S_UCHK;
            end
            S_UCHK:
            begin
                // rdata holds slot p_inc; distance measured at p_inc
                if (r_home == '0 || AW'(r_home - HW'(1)) == p_inc
                    || n_reg == CW'(SLOTS))
                begin
                    // end of the run: the last source slot still holds a copy
                    we = 1'b1;
                    wdata = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    we = 1'b1;
                    wdata = rdata;
                    // target slot p_reg gets follower, follower becomes target
                    p_next = p_inc;
                    n_next = n_reg + CW'(1);
                    state_next = S_URD;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data.status      = status_t'(st_reg);
    assign out_ch.data.found_size  = fs_reg;
    assign out_ch.data.entry_count = COUNT_W'(cnt_reg);
endmodule

### rtl/core/rhpt_checker.sv
// rhpt_checker: port-level assertions for robin_hood_pointer_table
// depends on rhpt_pkg

module rhpt_checker
    import rhpt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_status,
    input logic [31:0] out_found_size,
    input logic [10:0] out_count
);
    // no new item while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item accepted while result pending");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
            && $stable(out_count))
        else $error("result changed while stalled");

    // size shown only on success
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_DONE |-> out_found_size == '0)
        else $error("size on failed item");

    // stalled size holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_found_size))
        else $error("size changed while stalled");
endmodule

bind robin_hood_pointer_table rhpt_checker u_rhpt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.data.status),
    .out_found_size (out_ch.data.found_size),
    .out_count      (out_ch.data.entry_count)
);
